// ===== rtl/qte_pkg.sv =====
// Package with the types, constants and helpers of the quaternion to Euler angle converter.
package qte_pkg;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int ATAN_TABLE_LEN = 24;
	localparam int CORDIC_STEPS = (ANGLE_ITERATIONS < ATAN_TABLE_LEN) ?
		ANGLE_ITERATIONS : ATAN_TABLE_LEN;
	localparam int CORDIC_LAT = CORDIC_STEPS + 1;
	localparam int ROOT_STEPS = 29;

	typedef logic signed [33:0] term_t;
	typedef logic signed [36:0] cvec_t;
	typedef logic signed [26:0] ang_t;

	localparam logic [1:0] LOCK_NONE = 2'd0;
	localparam logic [1:0] LOCK_NEG = 2'd1;
	localparam logic [1:0] LOCK_POS = 2'd2;

	localparam logic [14:0] THR_RESET = 15'd16302;
	localparam logic [14:0] PITCH_LIM = 15'd11520;
	localparam logic [14:0] ANGLE_LIM = 15'd23040;
	localparam ang_t DEG180 = 27'sd11796480;

	localparam ang_t ATAN_TABLE [0:ATAN_TABLE_LEN-1] = '{
		27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
		27'sd234379, 27'sd117266, 27'sd58666, 27'sd29335,
		27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
		27'sd917, 27'sd458, 27'sd229, 27'sd115,
		27'sd57, 27'sd29, 27'sd14, 27'sd7,
		27'sd4, 27'sd2, 27'sd1, 27'sd0
	};

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [14:0] pitch_deg;
		logic signed [15:0] yaw_deg;
		logic signed [15:0] roll_deg;
		logic [1:0] lock_case;
	} euler_t;

	function automatic logic signed [15:0] to_deg128(input ang_t a, input logic [14:0] lim);
		logic signed [27:0] t;
		logic signed [27:0] l;
		t = (28'(a) + 28'sd256) >>> 9;
		l = $signed({13'b0, lim});
		if (t > l) begin
			t = l;
		end
		if (t < -l) begin
			t = -l;
		end
		return 16'(t);
	endfunction

endpackage

// ===== rtl/quaternion_to_euler.sv =====
// Top level of the quaternion to Euler angle converter.
// A beat passes the product, side, root and CORDIC stages; result and done are registered.
// Throughput: one beat per cycle; busy is never raised.
// The depth is set by a 29-stage square root and three 17-stage CORDIC pipelines.
// Reset clears all valid bits and sets the lock threshold to about 0.995.
// The receiver cannot stall, so results are never held back.
module quaternion_to_euler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  qte_pkg::quat_t     quat,
	output logic               done,
	output qte_pkg::euler_t    result,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_wdata
);

	typedef struct packed {
		logic [1:0] code;
		logic signed [29:0] c;
		qte_pkg::term_t yaw_num;
		qte_pkg::term_t yaw_den;
		qte_pkg::term_t roll_num;
		qte_pkg::term_t roll_den;
	} side_t;

	localparam qte_pkg::term_t ONE = 34'sd268435456;

	logic [14:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qte_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	logic v_s1;
	logic signed [31:0] wx_s1, yz_s1, xz_s1, wy_s1, xy_s1, wz_s1, xx_s1, yy_s1, zz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= quat.quat_w * quat.quat_x;
		yz_s1 <= quat.quat_y * quat.quat_z;
		xz_s1 <= quat.quat_x * quat.quat_z;
		wy_s1 <= quat.quat_w * quat.quat_y;
		xy_s1 <= quat.quat_x * quat.quat_y;
		wz_s1 <= quat.quat_w * quat.quat_z;
		xx_s1 <= quat.quat_x * quat.quat_x;
		yy_s1 <= quat.quat_y * quat.quat_y;
		zz_s1 <= quat.quat_z * quat.quat_z;
	end

	qte_pkg::term_t check;
	qte_pkg::term_t thr;
	side_t side_d;

	always_comb begin
		check = (34'(wx_s1) - 34'(yz_s1)) <<< 1;
		thr = $signed({5'b0, thr_q, 14'b0});
		side_d.yaw_num = (34'(xz_s1) + 34'(wy_s1)) <<< 1;
		side_d.yaw_den = ONE - ((34'(xx_s1) + 34'(yy_s1)) <<< 1);
		side_d.c = '0;
		if (check < -thr) begin
			side_d.code = qte_pkg::LOCK_NEG;
		end else if (check > thr) begin
			side_d.code = qte_pkg::LOCK_POS;
		end else begin
			side_d.code = qte_pkg::LOCK_NONE;
		end
		if (side_d.code == qte_pkg::LOCK_NONE) begin
			side_d.roll_num = (34'(xy_s1) + 34'(wz_s1)) <<< 1;
			side_d.roll_den = ONE - ((34'(xx_s1) + 34'(zz_s1)) <<< 1);
		end else begin
			side_d.roll_num = (34'(xz_s1) - 34'(wy_s1)) <<< 1;
			side_d.roll_den = ONE - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);
		end
		if (check > ONE) begin
			side_d.c = 30'(ONE);
		end else if (check < -ONE) begin
			side_d.c = -30'(ONE);
		end else begin
			side_d.c = 30'(check);
		end
	end

	logic v_s2, v_s3;
	side_t p_s2, p_s3;
	logic [57:0] csq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	logic [28:0] cabs;
	assign cabs = (p_s2.c < 0) ? 29'(-p_s2.c) : 29'(p_s2.c);

	always_ff @(posedge clk) begin
		p_s2 <= side_d;
		p_s3 <= p_s2;
		csq_s3 <= 58'(cabs) * 58'(cabs);
	end

	logic rt_v [0:qte_pkg::ROOT_STEPS];
	logic [57:0] rt_rem [0:qte_pkg::ROOT_STEPS];
	logic [57:0] rt_res [0:qte_pkg::ROOT_STEPS];
	side_t rt_p [0:qte_pkg::ROOT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v[0] <= 1'b0;
		end else begin
			rt_v[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		rt_rem[0] <= (58'd1 << 56) - csq_s3;
		rt_res[0] <= '0;
		rt_p[0] <= p_s3;
	end

	for (genvar k = 0; k < qte_pkg::ROOT_STEPS; k++) begin : g_root
		localparam logic [57:0] BIT = 58'd1 << (56 - 2 * k);
		logic [57:0] trial;
		assign trial = rt_res[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k+1] <= 1'b0;
			end else begin
				rt_v[k+1] <= rt_v[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_p[k+1] <= rt_p[k];
			if (rt_rem[k] >= trial) begin
				rt_rem[k+1] <= rt_rem[k] - trial;
				rt_res[k+1] <= (rt_res[k] >> 1) + BIT;
			end else begin
				rt_rem[k+1] <= rt_rem[k];
				rt_res[k+1] <= rt_res[k] >> 1;
			end
		end
	end

	side_t rp;
	qte_pkg::term_t pitch_num, pitch_den;
	assign rp = rt_p[qte_pkg::ROOT_STEPS];
	assign pitch_num = 34'(rp.c);
	assign pitch_den = $signed({5'b0, rt_res[qte_pkg::ROOT_STEPS][28:0]});

	logic pv, yv, rv;
	qte_pkg::ang_t pitch_ang, yaw_ang, roll_ang;

	qte_cordic u_pitch (
		.clk(clk), .arst_n(arst_n), .in_valid(rt_v[qte_pkg::ROOT_STEPS]),
		.num(pitch_num), .den(pitch_den), .out_valid(pv), .angle(pitch_ang)
	);

	qte_cordic u_yaw (
		.clk(clk), .arst_n(arst_n), .in_valid(rt_v[qte_pkg::ROOT_STEPS]),
		.num(rp.yaw_num), .den(rp.yaw_den), .out_valid(yv), .angle(yaw_ang)
	);

	qte_cordic u_roll (
		.clk(clk), .arst_n(arst_n), .in_valid(rt_v[qte_pkg::ROOT_STEPS]),
		.num(rp.roll_num), .den(rp.roll_den), .out_valid(rv), .angle(roll_ang)
	);

	logic [1:0] cd_s [0:qte_pkg::CORDIC_LAT-1];

	always_ff @(posedge clk) begin
		cd_s[0] <= rp.code;
	end

	for (genvar j = 1; j < qte_pkg::CORDIC_LAT; j++) begin : g_code
		always_ff @(posedge clk) begin
			cd_s[j] <= cd_s[j-1];
		end
	end

	logic [1:0] code_o;
	logic signed [15:0] pitch_r, yaw_r, roll_r;
	qte_pkg::euler_t res_d;

	assign code_o = cd_s[qte_pkg::CORDIC_LAT-1];

	always_comb begin
		pitch_r = qte_pkg::to_deg128(pitch_ang, qte_pkg::PITCH_LIM);
		yaw_r = qte_pkg::to_deg128(yaw_ang, qte_pkg::ANGLE_LIM);
		roll_r = qte_pkg::to_deg128(roll_ang, qte_pkg::ANGLE_LIM);
		res_d.lock_case = code_o;
		unique case (code_o)
			qte_pkg::LOCK_NEG: begin
				res_d.pitch_deg = -15'sd11520;
				res_d.yaw_deg = '0;
				res_d.roll_deg = -roll_r;
			end
			qte_pkg::LOCK_POS: begin
				res_d.pitch_deg = 15'sd11520;
				res_d.yaw_deg = '0;
				res_d.roll_deg = roll_r;
			end
			default: begin
				res_d.pitch_deg = 15'(pitch_r);
				res_d.yaw_deg = yaw_r;
				res_d.roll_deg = roll_r;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= pv && yv && rv;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2 in degrees scaled by 65536.
module qte_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  qte_pkg::term_t       num,
	input  qte_pkg::term_t       den,
	output logic                 out_valid,
	output qte_pkg::ang_t        angle
);

	qte_pkg::cvec_t x_s [0:qte_pkg::CORDIC_STEPS];
	qte_pkg::cvec_t y_s [0:qte_pkg::CORDIC_STEPS];
	qte_pkg::ang_t a_s [0:qte_pkg::CORDIC_STEPS];
	logic z_s [0:qte_pkg::CORDIC_STEPS];
	logic v_s [0:qte_pkg::CORDIC_STEPS];

	qte_pkg::cvec_t x_pre;
	qte_pkg::cvec_t y_pre;
	qte_pkg::ang_t a_pre;

	always_comb begin
		x_pre = 37'(den);
		y_pre = 37'(num);
		a_pre = '0;
		if (den < 0) begin
			x_pre = -37'(den);
			y_pre = -37'(num);
			a_pre = (num >= 0) ? qte_pkg::DEG180 : -qte_pkg::DEG180;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= x_pre;
		y_s[0] <= y_pre;
		a_s[0] <= a_pre;
		z_s[0] <= (num == 0) && (den == 0);
	end

	for (genvar i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			z_s[i+1] <= z_s[i];
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] + qte_pkg::ATAN_TABLE[i];
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] - qte_pkg::ATAN_TABLE[i];
			end
		end
	end

	assign out_valid = v_s[qte_pkg::CORDIC_STEPS];
	assign angle = z_s[qte_pkg::CORDIC_STEPS] ? '0 : a_s[qte_pkg::CORDIC_STEPS];

endmodule
